[hw/rtl/circle_segment_intersect_assert.svh]
// Assertion macros shared by the circle/segment contact test RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef CIRCLE_SEGMENT_INTERSECT_ASSERT_SVH
`define CIRCLE_SEGMENT_INTERSECT_ASSERT_SVH

// Check post in the same cycle as pre.
`define CSI_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("circle_segment_intersect: same-cycle check failed");

// Check post in the cycle after pre.
`define CSI_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("circle_segment_intersect: next-cycle check failed");

`endif

[hw/rtl/csi_pkg.sv]
// Package for the circle/segment contact test: widths, stage count and
// the structs passed between pipeline modules. No dependencies.
package csi_pkg;

   // Coordinate width; every other width follows from it.
   localparam int COORD_WIDTH = 16;
   localparam int RAD_WIDTH   = COORD_WIDTH - 1;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int R2_WIDTH    = 2 * RAD_WIDTH;

   // Magnitudes of |num|, den and r2 all stay below 2^(2*COORD_WIDTH+1).
   localparam int MAG_WIDTH   = 2 * COORD_WIDTH + 1;
   localparam int HALF_WIDTH  = (MAG_WIDTH + 1) / 2;
   localparam int HI_WIDTH    = MAG_WIDTH - HALF_WIDTH;
   localparam int HH_WIDTH    = 2 * HI_WIDTH;
   localparam int HL_WIDTH    = HI_WIDTH + HALF_WIDTH;
   localparam int LL_WIDTH    = 2 * HALF_WIDTH;
   localparam int WIDE_WIDTH  = 2 * MAG_WIDTH;

   // Register stages from accepted beat to result register.
   localparam int STAGES = 7;

   // Load enables of the three front stages.
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } csi_front_ctl_type;

   // Load enables of the split multiplier.
   typedef struct packed {
      logic a_en;
      logic b_en;
   } csi_mul_ctl_type;

   // Sums produced by the front end.
   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] ua;
      logic signed [SUM_WIDTH-1:0] ubn;
      logic signed [SUM_WIDTH-1:0] da;
      logic signed [SUM_WIDTH-1:0] db;
      logic signed [SUM_WIDTH-1:0] num;
      logic signed [SUM_WIDTH-1:0] den;
      logic [R2_WIDTH-1:0]         r2;
   } csi_sums_type;

endpackage

[hw/rtl/csi_req_if.sv]
// Request channel: one circle and one segment per beat.
// Depends on csi_pkg for the field widths.
interface csi_req_if import csi_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic [RAD_WIDTH-1:0]          radius;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (
      output valid, center_x, center_y, radius, start_x, start_y, end_x, end_y,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, radius, start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

[hw/rtl/csi_rsp_if.sv]
// Response channel: one hit flag per beat.
// Imports csi_pkg, though it has no sized fields beyond one bit.
interface csi_rsp_if import csi_pkg::*; ();
   logic valid;
   logic ready;
   logic hit;

   modport source (
      output valid, hit,
      input  ready
   );
   modport sink (
      input  valid, hit,
      output ready
   );
endinterface

[hw/rtl/csi_front.sv]
// Front end of the contact test: differences, products and sums,
// three register stages. Depends on csi_pkg.
module csi_front import csi_pkg::*; (
   input  logic                          clock,
   input  csi_front_ctl_type             ctl,
   input  logic signed [COORD_WIDTH-1:0] center_x,
   input  logic signed [COORD_WIDTH-1:0] center_y,
   input  logic [RAD_WIDTH-1:0]          radius,
   input  logic signed [COORD_WIDTH-1:0] start_x,
   input  logic signed [COORD_WIDTH-1:0] start_y,
   input  logic signed [COORD_WIDTH-1:0] end_x,
   input  logic signed [COORD_WIDTH-1:0] end_y,
   output csi_sums_type                  sums
);

   // Stage 1: coordinate differences
   logic signed [DIFF_WIDTH-1:0] dx_ff, dy_ff, ex_ff, ey_ff, fx_ff, fy_ff;
   logic signed [DIFF_WIDTH-1:0] dx_in, dy_in, ex_in, ey_in, fx_in, fy_in;
   logic [RAD_WIDTH-1:0]         rad_ff;

   // Stage 2: products
   logic signed [PROD_WIDTH-1:0] exdx_ff, eydy_ff, fxdx_ff, fydy_ff;
   logic signed [PROD_WIDTH-1:0] exex_ff, eyey_ff, fxfx_ff, fyfy_ff;
   logic signed [PROD_WIDTH-1:0] dyex_ff, dxey_ff, dxdx_ff, dydy_ff;
   logic signed [PROD_WIDTH-1:0] exdx_in, eydy_in, fxdx_in, fydy_in;
   logic signed [PROD_WIDTH-1:0] exex_in, eyey_in, fxfx_in, fyfy_in;
   logic signed [PROD_WIDTH-1:0] dyex_in, dxey_in, dxdx_in, dydy_in;
   logic [R2_WIDTH-1:0]          r2_ff, r2_in;

   // Stage 3: sums
   csi_sums_type sums_ff, sums_in;

   // Form B-A, C-A and C-B
   always_comb begin
      dx_in = DIFF_WIDTH'(end_x)    - DIFF_WIDTH'(start_x);
      dy_in = DIFF_WIDTH'(end_y)    - DIFF_WIDTH'(start_y);
      ex_in = DIFF_WIDTH'(center_x) - DIFF_WIDTH'(start_x);
      ey_in = DIFF_WIDTH'(center_y) - DIFF_WIDTH'(start_y);
      fx_in = DIFF_WIDTH'(center_x) - DIFF_WIDTH'(end_x);
      fy_in = DIFF_WIDTH'(center_y) - DIFF_WIDTH'(end_y);
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         rad_ff <= radius;
      end
   end

   // Multiply every pair the three tests need
   always_comb begin
      exdx_in = PROD_WIDTH'(ex_ff) * PROD_WIDTH'(dx_ff);
      eydy_in = PROD_WIDTH'(ey_ff) * PROD_WIDTH'(dy_ff);
      fxdx_in = PROD_WIDTH'(fx_ff) * PROD_WIDTH'(dx_ff);
      fydy_in = PROD_WIDTH'(fy_ff) * PROD_WIDTH'(dy_ff);
      exex_in = PROD_WIDTH'(ex_ff) * PROD_WIDTH'(ex_ff);
      eyey_in = PROD_WIDTH'(ey_ff) * PROD_WIDTH'(ey_ff);
      fxfx_in = PROD_WIDTH'(fx_ff) * PROD_WIDTH'(fx_ff);
      fyfy_in = PROD_WIDTH'(fy_ff) * PROD_WIDTH'(fy_ff);
      dyex_in = PROD_WIDTH'(dy_ff) * PROD_WIDTH'(ex_ff);
      dxey_in = PROD_WIDTH'(dx_ff) * PROD_WIDTH'(ey_ff);
      dxdx_in = PROD_WIDTH'(dx_ff) * PROD_WIDTH'(dx_ff);
      dydy_in = PROD_WIDTH'(dy_ff) * PROD_WIDTH'(dy_ff);
      r2_in   = R2_WIDTH'(rad_ff) * R2_WIDTH'(rad_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         exdx_ff <= exdx_in;
         eydy_ff <= eydy_in;
         fxdx_ff <= fxdx_in;
         fydy_ff <= fydy_in;
         exex_ff <= exex_in;
         eyey_ff <= eyey_in;
         fxfx_ff <= fxfx_in;
         fyfy_ff <= fyfy_in;
         dyex_ff <= dyex_in;
         dxey_ff <= dxey_in;
         dxdx_ff <= dxdx_in;
         dydy_ff <= dydy_in;
         r2_ff   <= r2_in;
      end
   end

   // Combine: ua, negated ub, endpoint distances, line numerator and squared norm
   always_comb begin
      sums_in.ua  = SUM_WIDTH'(exdx_ff) + SUM_WIDTH'(eydy_ff);
      sums_in.ubn = SUM_WIDTH'(fxdx_ff) + SUM_WIDTH'(fydy_ff);
      sums_in.da  = SUM_WIDTH'(exex_ff) + SUM_WIDTH'(eyey_ff);
      sums_in.db  = SUM_WIDTH'(fxfx_ff) + SUM_WIDTH'(fyfy_ff);
      sums_in.num = SUM_WIDTH'(dyex_ff) - SUM_WIDTH'(dxey_ff);
      sums_in.den = SUM_WIDTH'(dxdx_ff) + SUM_WIDTH'(dydy_ff);
      sums_in.r2  = r2_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

[hw/rtl/csi_wide_mul.sv]
// Two-stage unsigned multiplier for the wide line-distance products:
// half-word partial products, then one shifted sum. Depends on csi_pkg.
module csi_wide_mul import csi_pkg::*; (
   input  logic                  clock,
   input  csi_mul_ctl_type       ctl,
   input  logic [MAG_WIDTH-1:0]  a,
   input  logic [MAG_WIDTH-1:0]  b,
   output logic [WIDE_WIDTH-1:0] prod
);

   logic [HI_WIDTH-1:0]   a_hi, b_hi;
   logic [HALF_WIDTH-1:0] a_lo, b_lo;
   logic [HH_WIDTH-1:0]   hh_ff, hh_in;
   logic [HL_WIDTH-1:0]   hl_ff, hl_in, lh_ff, lh_in;
   logic [LL_WIDTH-1:0]   ll_ff, ll_in;
   logic [WIDE_WIDTH-1:0] prod_ff, prod_in;

   // Split operands and form the four partial products
   always_comb begin
      a_hi  = a[MAG_WIDTH-1:HALF_WIDTH];
      a_lo  = a[HALF_WIDTH-1:0];
      b_hi  = b[MAG_WIDTH-1:HALF_WIDTH];
      b_lo  = b[HALF_WIDTH-1:0];
      hh_in = HH_WIDTH'(a_hi) * HH_WIDTH'(b_hi);
      hl_in = HL_WIDTH'(a_hi) * HL_WIDTH'(b_lo);
      lh_in = HL_WIDTH'(a_lo) * HL_WIDTH'(b_hi);
      ll_in = LL_WIDTH'(a_lo) * LL_WIDTH'(b_lo);
   end

   always_ff @(posedge clock) begin
      if (ctl.a_en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
   end

   // Align and add the partial products
   always_comb begin
      prod_in = (WIDE_WIDTH'(hh_ff) << (2 * HALF_WIDTH))
              + ((WIDE_WIDTH'(hl_ff) + WIDE_WIDTH'(lh_ff)) << HALF_WIDTH)
              + WIDE_WIDTH'(ll_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.b_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[hw/rtl/circle_segment_intersect.sv]
// Circle against line segment contact test, top level.
// Depends on csi_pkg, csi_req_if, csi_rsp_if, csi_front, csi_wide_mul
// and the assertion macros in circle_segment_intersect_assert.svh.
//
// Usage: each req_if beat carries a circle (center, radius) and a segment
// (start, end); each rsp_if beat returns hit, set when the closed disc and
// the closed segment share a point. Results come back in request order,
// one per request.
// Throughput: one beat per cycle while no stall holds the pipeline, set by the
// seven-stage pipeline (differences, products, sums, branch select, split
// partial products, product sum, compare), which takes a new beat every
// cycle unless it is stalled.
// Stall: when rsp_if.ready is low a valid result register holds; each stage
// holds only while its successor holds, so empty stages keep filling and
// req_if.ready drops only once every stage carries a beat.
// Reset: synchronous, active high; clears all stage valid bits, so the
// block comes out of reset empty and ready. Payload registers are not reset.
`include "circle_segment_intersect_assert.svh"

module circle_segment_intersect import csi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   csi_req_if.sink   req_if,
   csi_rsp_if.source rsp_if
);

   // Stage valid bits and load enables; stage STAGES is the result register
   logic [STAGES:1] v_ff, v_in;
   logic [STAGES:1] en;

   csi_front_ctl_type front_ctl;
   csi_mul_ctl_type   mul_ctl;
   csi_sums_type      sums;

   // Stage 4: branch select and multiplier operands
   logic                  ua_le, ub_le;
   logic signed [SUM_WIDTH-1:0] ep_dist, num_abs, r2_ext;
   logic                  ep_in, ep_hit_in;
   logic                  ep4_ff, eh4_ff;
   logic [MAG_WIDTH-1:0]  na_ff, na_in, den_ff, den_in, r2m_ff, r2m_in;

   // Stages 5 and 6: branch flags ride beside the multipliers
   logic                  ep5_ff, eh5_ff, ep6_ff, eh6_ff;
   logic [WIDE_WIDTH-1:0] nn, rd;

   // Stage 7: result
   logic                  hit_ff, hit_in;

   // Each stage advances when it is empty or its successor advances
   always_comb begin
      en[STAGES] = !v_ff[STAGES] || rsp_if.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in = (en & {v_ff[STAGES-1:1], req_if.valid}) | (~en & v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_if.ready = en[1];

   // Stages 1 to 3, plus the multiplier load enables for stages 5 and 6
   always_comb begin
      front_ctl.s1_en = en[1];
      front_ctl.s2_en = en[2];
      front_ctl.s3_en = en[3];
      mul_ctl.a_en    = en[5];
      mul_ctl.b_en    = en[6];
   end

   csi_front u_front (
      .clock    (clock),
      .ctl      (front_ctl),
      .center_x (req_if.center_x),
      .center_y (req_if.center_y),
      .radius   (req_if.radius),
      .start_x  (req_if.start_x),
      .start_y  (req_if.start_y),
      .end_x    (req_if.end_x),
      .end_y    (req_if.end_y),
      .sums     (sums)
   );

   // Pick the endpoint test, or set up the line-distance products
   always_comb begin
      ua_le     = sums.ua[SUM_WIDTH-1] || (sums.ua == '0);
      ub_le     = !sums.ubn[SUM_WIDTH-1];
      ep_in     = ua_le || ub_le;
      ep_dist   = ua_le ? sums.da : sums.db;
      r2_ext    = SUM_WIDTH'(sums.r2);
      ep_hit_in = ($signed(ep_dist) <= $signed(r2_ext));
      num_abs   = sums.num[SUM_WIDTH-1] ? -sums.num : sums.num;
      na_in     = num_abs[MAG_WIDTH-1:0];
      den_in    = sums.den[MAG_WIDTH-1:0];
      r2m_in    = MAG_WIDTH'(sums.r2);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         ep4_ff <= ep_in;
         eh4_ff <= ep_hit_in;
         na_ff  <= na_in;
         den_ff <= den_in;
         r2m_ff <= r2m_in;
      end
   end

   // Stages 5 and 6: num squared and r2 times den
   csi_wide_mul u_mul_num (
      .clock (clock),
      .ctl   (mul_ctl),
      .a     (na_ff),
      .b     (na_ff),
      .prod  (nn)
   );

   csi_wide_mul u_mul_rad (
      .clock (clock),
      .ctl   (mul_ctl),
      .a     (r2m_ff),
      .b     (den_ff),
      .prod  (rd)
   );

   always_ff @(posedge clock) begin
      if (en[5]) begin
         ep5_ff <= ep4_ff;
         eh5_ff <= eh4_ff;
      end
      if (en[6]) begin
         ep6_ff <= ep5_ff;
         eh6_ff <= eh5_ff;
      end
   end

   // Stage 7: final compare into the result register
   always_comb begin
      hit_in = ep6_ff ? eh6_ff : (nn <= rd);
   end

   always_ff @(posedge clock) begin
      if (en[STAGES]) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_if.valid = v_ff[STAGES];
   assign rsp_if.hit   = hit_ff;

   // Pipeline bookkeeping checks
   `CSI_ASSERT_NEXT(a_accept_enters, req_if.valid && req_if.ready, v_ff[1])
   `CSI_ASSERT_NOW(a_ready_has_room, req_if.ready, !v_ff[1] || en[2])
   `CSI_ASSERT_NEXT(a_result_loads, en[STAGES] && v_ff[STAGES-1], v_ff[STAGES])
   `CSI_ASSERT_NEXT(a_bubble_passes, en[STAGES] && !v_ff[STAGES-1], !v_ff[STAGES])
   `CSI_ASSERT_NEXT(a_select_holds, v_ff[4] && !en[4], v_ff[4] && $stable(na_ff))

endmodule
